[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/dds_pkg.sv]
// Shared types and constants of the dense shortest-path engine.
// No dependencies; imported by the relax unit and the top level.
`default_nettype none

package dds_pkg;

  localparam int VID_BITS  = 6;
  localparam int DIST_BITS = 22;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;

  // One entry of the per-vertex state memory.
  typedef struct packed {
    logic [DIST_BITS-1:0] path_len;
    logic [VID_BITS-1:0]  pred;
    logic                 reached;
    logic                 has_pred;
    logic                 visited;
  } vtx_t;

  // Running minimum of the selection scan.
  typedef struct packed {
    logic                 found;
    logic [VID_BITS-1:0]  vid;
    logic [DIST_BITS-1:0] path_len;
  } sel_t;

endpackage

`default_nettype wire

[rtl/dds_relax.sv]
// Relaxation of one vertex entry and the running selection of the next vertex.
// Depends on dds_pkg for the entry and selection types.
`default_nettype none

module dds_relax #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          valid,
  input  dds_pkg::vtx_t                 entry,
  input  logic [WEIGHT_BITS-1:0]        weight,
  input  logic [dds_pkg::VID_BITS-1:0]  index,
  input  logic [dds_pkg::VID_BITS-1:0]  u,
  input  logic [dds_pkg::DIST_BITS-1:0] dist_u,
  output dds_pkg::vtx_t                 entry_next,
  output dds_pkg::sel_t                 sel_next
);
  import dds_pkg::*;

  localparam int SUM_BITS = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  logic [SUM_BITS-1:0]  sum;
  logic [DIST_BITS-1:0] cand;
  sel_t                 sel;

  // Candidate distance through the selected vertex, saturated.
  assign sum  = SUM_BITS'(dist_u) + SUM_BITS'(weight);
  assign cand = (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];

  // The selected vertex is marked visited; other unvisited neighbors are relaxed.
  always_comb begin
    entry_next = entry;
    if (index == u) begin
      entry_next.visited = 1'b1;
    end else if (weight != '0 && !entry.visited &&
                 (!entry.reached || entry.path_len > cand)) begin
      entry_next.path_len = cand;
      entry_next.reached  = 1'b1;
      entry_next.pred     = u;
      entry_next.has_pred = 1'b1;
    end
  end

  // Track the unvisited reached vertex of smallest distance, lowest index first.
  always_comb begin
    sel_next = sel;
    if (valid && !entry_next.visited && entry_next.reached &&
        (!sel.found || entry_next.path_len < sel.path_len)) begin
      sel_next.found    = 1'b1;
      sel_next.vid      = index;
      sel_next.path_len = entry_next.path_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sel.found <= 1'b0;
    end else if (valid) begin
      sel <= sel_next;
    end
  end

endmodule

`default_nettype wire

[rtl/dense_dijkstra_shortest_path_top.sv]
// Dense single-source shortest paths over a stored weight matrix.
// Matrix write: taken while idle, busy stays low. Query with n vertices in use:
// state init of the n entries, then one relax pass per selected vertex
// (matrix and vertex memory reads), then n results on consecutive cycles;
// results cannot be stalled.
// After reset the matrix is cleared at one entry a cycle.
`default_nettype none

module dense_dijkstra_shortest_path_top #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [5:0]                    row_vertex,
  input  logic [5:0]                    column_vertex,
  input  logic [15:0]                   edge_weight,
  input  logic [5:0]                    source_vertex,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [6:0]                    cfg_data,
  output logic                          result_valid,
  output logic [dds_pkg::VID_BITS-1:0]  vertex,
  output logic [dds_pkg::DIST_BITS-1:0] distance,
  output logic [dds_pkg::VID_BITS-1:0]  parent,
  output logic                          reachable,
  output logic                          has_parent,
  output logic                          last
);
  import dds_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int MW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_RELAX,
    S_OUT
  } state_t;

  state_t               state;
  logic [MW-1:0]        clr_addr;
  logic [6:0]           vertex_count;
  logic [CW-1:0]        n_calc;
  logic [CW-1:0]        n_act;
  logic [VID_BITS-1:0]  src;
  logic                 src_ok;
  logic [CW-1:0]        idx;
  logic                 issue;
  logic                 p1_valid;
  logic [AW-1:0]        p1_idx;
  logic [AW-1:0]        u;
  logic [DIST_BITS-1:0] dist_u;
  logic                 round_end;
  logic                 relax_clear;

  // Weight matrix memory.
  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [WEIGHT_BITS-1:0] wq;
  logic                   w_we;
  logic [MW-1:0]          w_waddr;
  logic [WEIGHT_BITS-1:0] w_wdata;
  logic [MW-1:0]          w_raddr;
  logic [WEIGHT_BITS+15:0] w_ext;
  logic                   wr_in_range;

  // Per-vertex state memory.
  vtx_t          vmem [MAX_VERTICES];
  vtx_t          vq;
  logic          v_we;
  logic [AW-1:0] v_waddr;
  vtx_t          v_wdata;
  vtx_t          entry_next;
  sel_t          sel_next;
  logic          out_hp;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Active vertex count from the register: zero counts as one, large values clip.
  always_comb begin
    if (vertex_count == 7'd0) begin
      n_calc = CW'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_calc = CW'(MAX_VERTICES);
    end else begin
      n_calc = CW'(vertex_count);
    end
  end

  // Matrix write port: clearing pass after reset, or a write beat while idle.
  assign w_ext       = {{WEIGHT_BITS{1'b0}}, edge_weight};
  assign wr_in_range = (32'(row_vertex) < MAX_VERTICES) &&
                       (32'(column_vertex) < MAX_VERTICES);
  always_comb begin
    w_we    = 1'b0;
    w_waddr = clr_addr;
    w_wdata = '0;
    if (state == S_CLEAR) begin
      w_we = 1'b1;
    end else if (state == S_IDLE && start && !operation && wr_in_range) begin
      w_we    = 1'b1;
      w_waddr = MW'(row_vertex[AW-1:0]) * MW'(MAX_VERTICES) + MW'(column_vertex[AW-1:0]);
      w_wdata = w_ext[WEIGHT_BITS-1:0];
    end
  end

  // Row of the selected vertex, column walks with the scan index.
  assign w_raddr = MW'(u) * MW'(MAX_VERTICES) + MW'(idx[AW-1:0]);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    wq <= wmem[w_raddr];
  end

  // Vertex memory write port: init sweep or relax write-back.
  always_comb begin
    v_we    = 1'b0;
    v_waddr = idx[AW-1:0];
    v_wdata = '{path_len: '0, pred: '0, reached: (7'(idx) == 7'(src)),
                has_pred: 1'b0, visited: 1'b0};
    if (state == S_INIT) begin
      v_we = 1'b1;
    end else if (state == S_RELAX && p1_valid) begin
      v_we    = 1'b1;
      v_waddr = p1_idx;
      v_wdata = entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    vq <= vmem[idx[AW-1:0]];
  end

  // Scan control: one read issued per cycle, data back in the next cycle.
  assign issue       = (state == S_RELAX || state == S_OUT) && (idx < n_act);
  assign round_end   = (state == S_RELAX) && p1_valid &&
                       (CW'(p1_idx) == n_act - CW'(1));
  assign relax_clear = (state != S_RELAX) || round_end;

  dds_relax #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_relax (
    .clk       (clk),
    .rst       (rst),
    .clear     (relax_clear),
    .valid     (p1_valid && state == S_RELAX),
    .entry     (vq),
    .weight    (wq),
    .index     (VID_BITS'(p1_idx)),
    .u         (VID_BITS'(u)),
    .dist_u    (dist_u),
    .entry_next(entry_next),
    .sel_next  (sel_next)
  );

  assign out_hp = vq.reached && vq.has_pred;

  // Sequencer and registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      vertex_count <= 7'd64;
      p1_valid     <= 1'b0;
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      result_valid <= (state == S_OUT) && p1_valid;
      p1_valid     <= issue;
      if (issue) begin
        p1_idx <= idx[AW-1:0];
        idx    <= idx + CW'(1);
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MW'(1);
          if (clr_addr == MW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && operation) begin
            n_act  <= n_calc;
            src    <= source_vertex;
            src_ok <= (32'(source_vertex) < 32'(n_calc));
            idx    <= '0;
            state  <= S_INIT;
          end
        end
        S_INIT: begin
          if (idx == n_act - CW'(1)) begin
            idx <= '0;
            if (src_ok) begin
              u      <= src[AW-1:0];
              dist_u <= '0;
              state  <= S_RELAX;
            end else begin
              state <= S_OUT;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_RELAX: begin
          if (round_end) begin
            idx <= '0;
            if (sel_next.found) begin
              u      <= sel_next.vid[AW-1:0];
              dist_u <= sel_next.path_len;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (p1_valid) begin
            vertex       <= VID_BITS'(p1_idx);
            reachable    <= vq.reached;
            distance     <= vq.reached ? vq.path_len : '0;
            has_parent   <= out_hp;
            parent       <= out_hp ? vq.pred : '0;
            last         <= (CW'(p1_idx) == n_act - CW'(1));
            if (CW'(p1_idx) == n_act - CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/dds_checker.sv]
// Port-level checks of the shortest-path engine, bound to its top level.
// Depends on assert_macros.svh and on the top level's port names.
`default_nettype none
`include "assert_macros.svh"

module dds_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        operation,
  input wire logic        result_valid,
  input wire logic [5:0]  vertex,
  input wire logic [21:0] distance,
  input wire logic        reachable,
  input wire logic        has_parent,
  input wire logic        last
);

  // An accepted query makes the block busy on the next cycle.
  `ASSERT_NEXT(a_query_busy, start && !busy && operation, busy)

  // Results of one query come out on consecutive cycles until the last beat.
  `ASSERT_NEXT(a_results_dense, result_valid && !last, result_valid)

  // Vertices ascend by one from beat to beat within a query.
  `ASSERT_NEXT(a_vertex_step, result_valid && !last, vertex == 6'($past(vertex) + 6'd1))

  // An unreachable vertex has zero distance and no parent.
  `ASSERT_SAME(a_unreached_clean, result_valid && !reachable,
               distance == 22'd0 && !has_parent)

endmodule

bind dense_dijkstra_shortest_path_top dds_checker u_dds_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .operation   (operation),
  .result_valid(result_valid),
  .vertex      (vertex),
  .distance    (distance),
  .reachable   (reachable),
  .has_parent  (has_parent),
  .last        (last)
);

`default_nettype wire
